/* design/bipt_pkg.sv */
// shared types and constants of the bus i/o expander with pulse timer
// no dependencies
package bipt_pkg;

  localparam logic [7:0] CMD_RESET    = 8'hF0;
  localparam logic [7:0] CMD_ADDR     = 8'hF1;
  localparam logic [7:0] CMD_MODE     = 8'hF2;
  localparam logic [7:0] CMD_LEVEL    = 8'hF3;
  localparam logic [7:0] CMD_AWRITE   = 8'hF4;
  localparam logic [7:0] CMD_PULSE    = 8'hF5;
  localparam logic [7:0] CMD_IRQ      = 8'hF6;
  localparam logic [7:0] CMD_SET      = 8'hF7;
  localparam logic [7:0] CMD_CLR      = 8'hF8;
  localparam logic [7:0] CMD_TOGGLE   = 8'hF9;
  localparam logic [7:0] CMD_RDLEVEL  = 8'hFA;
  localparam logic [7:0] CMD_RDANALOG = 8'hFB;
  localparam logic [7:0] CMD_MEASURE  = 8'hFC;
  localparam logic [7:0] CMD_RDWIDTH  = 8'hFD;
  localparam logic [7:0] CMD_IRQ_A    = 8'hFE;
  localparam logic [7:0] CMD_IRQ_B    = 8'hFF;

  localparam logic [7:0] MODE_ANALOG_IN = 8'h42;
  localparam logic [7:0] MODE_ANALOG_OUT = 8'h80;
  localparam logic [7:0] MODE_DIGITAL_IN = 8'h02;

  localparam logic [1:0] PM_DIN  = 2'd0;
  localparam logic [1:0] PM_DOUT = 2'd1;
  localparam logic [1:0] PM_AIN  = 2'd2;
  localparam logic [1:0] PM_AOUT = 2'd3;

  localparam logic [2:0] KIND_REPLY  = 3'd0;
  localparam logic [2:0] KIND_LEVEL  = 3'd1;
  localparam logic [2:0] KIND_MODE   = 3'd2;
  localparam logic [2:0] KIND_ANALOG = 3'd3;
  localparam logic [2:0] KIND_ADDR   = 3'd4;
  localparam logic [2:0] KIND_RESET  = 3'd5;

  localparam int MAX_RES = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  pin;
    logic [15:0] value;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic start;   // item taken, datapath computes results and state
    logic pop;     // one result transfer done
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       done;   // results of the item ready
    logic [2:0] count;  // number of results
  } stat_t;

  function automatic logic [2:0] frame_len(input logic [7:0] c);
    case (c)
      CMD_MODE, CMD_LEVEL, CMD_IRQ_A: frame_len = 3'd3;
      CMD_AWRITE:                     frame_len = 3'd4;
      CMD_PULSE, CMD_MEASURE:         frame_len = 3'd7;
      default:                        frame_len = 3'd2;
    endcase
  endfunction

endpackage

/* design/bipt_if.sv */
// valid/ready channel interfaces for input items and results
// no dependencies
interface bipt_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  rx_byte;
  logic [31:0] now_us;
  logic [3:0]  pin_levels;
  logic [11:0] analog_0;
  logic [11:0] analog_1;
  logic [11:0] analog_2;
  logic [11:0] analog_3;
  modport source (output valid, operation, rx_byte, now_us, pin_levels,
                  analog_0, analog_1, analog_2, analog_3, input ready);
  modport sink (input valid, operation, rx_byte, now_us, pin_levels,
                analog_0, analog_1, analog_2, analog_3, output ready);
endinterface

interface bipt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [1:0]  result_pin;
  logic [15:0] result_value;
  logic        last;
  modport source (output valid, result_kind, result_pin, result_value, last,
                  input ready);
  modport sink (input valid, result_kind, result_pin, result_value, last,
                output ready);
endinterface

/* design/bipt_ctrl.sv */
// controller: accepts an item, waits for the datapath, sends its results
// depends on bipt_pkg
module bipt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           out_last_o,
  output logic [1:0]     out_sel_o,
  output bipt_pkg::cmd_t cmd_o,
  input  bipt_pkg::stat_t stat_i
);
  import bipt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;

  logic [1:0] state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] sel_q, sel_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_SEND);
  assign out_sel_o   = sel_q;
  assign out_last_o  = ({1'b0, sel_q} + 3'd1 == cnt_q);
  assign cmd_o.start = in_valid_i && in_ready_o;
  assign cmd_o.pop   = out_valid_o && out_ready_i;

  // sequencing
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    unique case (state_q)
      ST_IDLE: if (cmd_o.start) state_d = ST_CALC;
      ST_CALC: begin
        if (stat_i.done) begin
          cnt_d   = stat_i.count;
          sel_d   = 2'd0;
          state_d = (stat_i.count == 3'd0) ? ST_IDLE : ST_SEND;
        end
      end
      ST_SEND: begin
        if (out_ready_i) begin
          if (out_last_o) state_d = ST_IDLE;
          else sel_d = sel_q + 2'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 3'd0;
      sel_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
    end
  end

  a_send_has_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEND |-> cnt_q != 3'd0 && cnt_q <= 3'd4)
    else $error("send without results");
  a_sel_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEND |-> {1'b0, sel_q} < cnt_q)
    else $error("result select past count");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> state_q == ST_CALC)
    else $error("accept not followed by calc");
endmodule

/* design/bipt_dp.sv */
// datapath: frame buffer, per-pin state, one pin per cycle on ticks
// depends on bipt_pkg
module bipt_dp #(
  parameter int PIN_COUNT   = 4,
  parameter int ANALOG_BITS = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bipt_pkg::cmd_t  cmd_i,
  output bipt_pkg::stat_t stat_o,
  input  logic            operation_i,
  input  logic [7:0]      rx_byte_i,
  input  logic [31:0]     now_us_i,
  input  logic [3:0]      pin_levels_i,
  input  logic [11:0]     analog_0_i,
  input  logic [11:0]     analog_1_i,
  input  logic [11:0]     analog_2_i,
  input  logic [11:0]     analog_3_i,
  input  logic [1:0]      sel_i,
  output bipt_pkg::res_t  res_o
);
  import bipt_pkg::*;

  localparam int PW = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
  localparam logic [15:0] AMASK = 16'((32'd1 << ANALOG_BITS) - 32'd1);

  // latched item
  logic        op_q;
  logic [7:0]  byte_q;
  logic [31:0] now_q;
  logic [3:0]  lv_q;
  logic [11:0] an_q [4];

  logic [7:0] fcmd_q;
  logic [2:0] fcnt_q;
  logic [7:0] args_q [6];

  logic [1:0]  mode_q   [PIN_COUNT];
  logic [7:0]  level_q  [PIN_COUNT];
  logic [15:0] aval_q   [PIN_COUNT];
  logic [7:0]  wait_q   [PIN_COUNT];
  logic [31:0] mstart_q [PIN_COUNT];
  logic [31:0] mdead_q  [PIN_COUNT];
  logic [31:0] mres_q   [PIN_COUNT];
  logic [7:0]  pcode_q  [PIN_COUNT];
  logic [31:0] pend_q   [PIN_COUNT];

  res_t       res_q [MAX_RES];
  logic [2:0] n_q;
  logic       busy_q;
  logic       done_q;
  logic [3:0] step_q;   // tick: pin index; byte: single step

  assign res_o        = res_q[sel_i];
  assign stat_o.count = n_q;
  assign stat_o.done  = done_q;

  // tick pin under work
  logic [PW-1:0] tp;
  logic          tlv;
  logic [15:0]   tav;
  assign tp  = step_q[PW-1:0];
  assign tlv = (step_q < 4'd4) ? lv_q[step_q[1:0]] : 1'b0;
  assign tav = (step_q < 4'd4) ? (16'(an_q[step_q[1:0]]) & AMASK) : 16'd0;

  // frame decode
  logic [7:0]  ex_p, ex_a;
  logic [31:0] ex_t;
  logic [2:0]  cnt_inc;
  logic        ex_now;
  logic [PW-1:0] ep;
  logic        p_ok;
  always_comb begin
    cnt_inc = fcnt_q + 3'd1;
    ex_now  = (cnt_inc == 3'd0) || (cnt_inc >= frame_len(fcmd_q));
    ex_p = (fcnt_q == 3'd1) ? byte_q : args_q[0];
    ex_a = (fcnt_q == 3'd2) ? byte_q : args_q[1];
    ex_t = {args_q[2], args_q[3], args_q[4], byte_q};
    ep   = ex_p[PW-1:0];
    p_ok = ({24'd0, ex_p} < 32'(PIN_COUNT));
  end

  function automatic res_t mk(input logic [2:0] k, input logic [1:0] p,
                              input logic [15:0] v);
    res_t r;
    r.kind = k; r.pin = p; r.value = v;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      n_q <= '0;
      fcmd_q <= '0;
      fcnt_q <= '0;
      for (int i = 0; i < PIN_COUNT; i++) begin
        mode_q[i] <= '0; level_q[i] <= '0; aval_q[i] <= '0; wait_q[i] <= '0;
        mstart_q[i] <= '0; mdead_q[i] <= '0; mres_q[i] <= '0;
        pcode_q[i] <= '0; pend_q[i] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        // capture the item
        op_q <= operation_i; byte_q <= rx_byte_i; now_q <= now_us_i;
        lv_q <= pin_levels_i;
        an_q[0] <= analog_0_i; an_q[1] <= analog_1_i;
        an_q[2] <= analog_2_i; an_q[3] <= analog_3_i;
        busy_q <= 1'b1;
        step_q <= '0;
        n_q <= '0;
      end else if (busy_q && op_q) begin
        // tick: one pin a cycle
        if (mode_q[tp] == PM_DIN) begin
          level_q[tp] <= {7'd0, tlv};
          if (wait_q[tp] != 8'd0) begin
            if ((wait_q[tp] == 8'd1 && tlv) || (wait_q[tp] == 8'd2 && !tlv)) begin
              mres_q[tp] <= now_q - mstart_q[tp];
              wait_q[tp] <= '0;
            end else if (mdead_q[tp] <= now_q) begin
              mres_q[tp] <= '0;
              wait_q[tp] <= '0;
            end
          end
        end else if (mode_q[tp] == PM_AIN) begin
          aval_q[tp] <= tav;
        end else if (mode_q[tp] == PM_DOUT && pcode_q[tp] != 8'd0 &&
                     n_q < 3'd4 && pend_q[tp] <= now_q) begin
          res_q[n_q[1:0]] <= mk(KIND_LEVEL, 2'(step_q),
                               (pcode_q[tp] == 8'd1) ? 16'd0 : 16'd1);
          n_q <= n_q + 3'd1;
          pend_q[tp] <= '0;
          pcode_q[tp] <= '0;
        end
        if (step_q == 4'(PIN_COUNT - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q + 4'd1;
        end
      end else if (busy_q) begin
        // bus byte: one step
        busy_q <= 1'b0;
        done_q <= 1'b1;
        if (fcnt_q == 3'd0) begin
          if (byte_q == CMD_RESET) begin
            fcmd_q <= '0;
            for (int i = 0; i < PIN_COUNT; i++) begin
              mode_q[i] <= '0; level_q[i] <= '0; aval_q[i] <= '0; wait_q[i] <= '0;
              mstart_q[i] <= '0; mdead_q[i] <= '0; mres_q[i] <= '0;
              pcode_q[i] <= '0; pend_q[i] <= '0;
            end
            res_q[0] <= mk(KIND_RESET, 2'd0, 16'd0);
            n_q <= 3'd1;
          end else if (byte_q == CMD_IRQ) begin
            for (int k = 0; k < MAX_RES; k++) res_q[k] <= mk(KIND_REPLY, 2'd0, 16'd0);
            n_q <= 3'd4;
          end else if (byte_q > CMD_RESET) begin
            fcmd_q <= byte_q;
            fcnt_q <= 3'd1;
          end
        end else if (!ex_now) begin
          args_q[fcnt_q - 3'd1] <= byte_q;
          fcnt_q <= cnt_inc;
        end else begin
          fcnt_q <= '0;
          if (fcmd_q == CMD_ADDR) begin
            fcmd_q <= '0;
            for (int i = 0; i < PIN_COUNT; i++) begin
              mode_q[i] <= '0; level_q[i] <= '0; aval_q[i] <= '0; wait_q[i] <= '0;
              mstart_q[i] <= '0; mdead_q[i] <= '0; mres_q[i] <= '0;
              pcode_q[i] <= '0; pend_q[i] <= '0;
            end
            res_q[0] <= mk(KIND_ADDR, 2'd0, {8'd0, ex_p});
            res_q[1] <= mk(KIND_RESET, 2'd0, 16'd0);
            n_q <= 3'd2;
          end else if (p_ok) begin
            case (fcmd_q)
              CMD_MODE: begin
                if (ex_a == MODE_ANALOG_IN) mode_q[ep] <= PM_AIN;
                else if (ex_a == 8'h80 || ex_a == 8'h81 || ex_a == 8'h83)
                  mode_q[ep] <= PM_AOUT;
                else if (ex_a == MODE_DIGITAL_IN) mode_q[ep] <= PM_DIN;
                else if (ex_a == 8'h00 || ex_a == 8'h01 || ex_a == 8'h03)
                  mode_q[ep] <= PM_DOUT;
                res_q[0] <= mk(KIND_MODE, ex_p[1:0], {8'd0, ex_a});
                n_q <= 3'd1;
              end
              CMD_LEVEL: begin
                level_q[ep] <= ex_a;
                res_q[0] <= mk(KIND_LEVEL, ex_p[1:0], {8'd0, ex_a});
                n_q <= 3'd1;
              end
              CMD_AWRITE: begin
                aval_q[ep] <= {ex_a, byte_q};
                res_q[0] <= mk(KIND_ANALOG, ex_p[1:0], {ex_a, byte_q});
                n_q <= 3'd1;
              end
              CMD_PULSE: begin
                pcode_q[ep] <= ex_a + 8'd1;
                pend_q[ep] <= now_q + ex_t;
                res_q[0] <= mk(KIND_LEVEL, ex_p[1:0], (ex_a == 8'd0) ? 16'd1 : 16'd0);
                n_q <= 3'd1;
              end
              CMD_MEASURE: begin
                wait_q[ep] <= ex_a + 8'd1;
                mstart_q[ep] <= now_q;
                mdead_q[ep] <= now_q + ex_t;
                mres_q[ep] <= 32'hFFFF_FFFF;
              end
              CMD_SET: begin
                level_q[ep] <= 8'd1;
                res_q[0] <= mk(KIND_LEVEL, ex_p[1:0], 16'd1);
                n_q <= 3'd1;
              end
              CMD_CLR: begin
                level_q[ep] <= 8'd0;
                res_q[0] <= mk(KIND_LEVEL, ex_p[1:0], 16'd0);
                n_q <= 3'd1;
              end
              CMD_TOGGLE: begin
                level_q[ep] <= (level_q[ep] == 8'd1) ? 8'd0 : 8'd1;
                res_q[0] <= mk(KIND_LEVEL, ex_p[1:0],
                               (level_q[ep] == 8'd1) ? 16'd0 : 16'd1);
                n_q <= 3'd1;
              end
              CMD_RDLEVEL: begin
                res_q[0] <= mk(KIND_REPLY, 2'd0, {8'd0, level_q[ep]});
                n_q <= 3'd1;
              end
              CMD_RDANALOG: begin
                res_q[0] <= mk(KIND_REPLY, 2'd0, {8'd0, aval_q[ep][15:8]});
                res_q[1] <= mk(KIND_REPLY, 2'd0, {8'd0, aval_q[ep][7:0]});
                n_q <= 3'd2;
              end
              CMD_RDWIDTH: begin
                res_q[0] <= mk(KIND_REPLY, 2'd0, {8'd0, mres_q[ep][31:24]});
                res_q[1] <= mk(KIND_REPLY, 2'd0, {8'd0, mres_q[ep][23:16]});
                res_q[2] <= mk(KIND_REPLY, 2'd0, {8'd0, mres_q[ep][15:8]});
                res_q[3] <= mk(KIND_REPLY, 2'd0, {8'd0, mres_q[ep][7:0]});
                n_q <= 3'd4;
              end
              default: ;
            endcase
          end
        end
      end
    end
  end

  a_done_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.done |-> n_q <= 3'd4)
    else $error("too many results");
  a_frame_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q != 3'd0 |-> fcnt_q < frame_len(fcmd_q))
    else $error("frame count beyond length");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.done |=> !stat_o.done)
    else $error("done held");
endmodule

/* design/bus_io_expander_pulse_timer.sv */
// top level of the bus i/o expander with pulse generator and width timer
// depends on bipt_pkg, bipt_if, bipt_ctrl, bipt_dp
//
// Input channel in_i carries one item: a bus byte (operation 0) or a tick
// (operation 1) with the time, pin levels and converter samples. Output
// channel out_o carries result items; last marks the final result of an
// item. An item that causes no result produces no transfer.
// Timing: a bus byte is captured when taken and worked on by the datapath in
// a single step; its registered done flag hands it to the controller, which
// frees the input if there is no result and else sends the results one by one.
// A tick walks the pins one per cycle, then hands over its results the same way.
// The per-item cost is set by the one-item-at-a-time handshake between
// controller and datapath; a byte yields up to four replies and a tick up to
// four pulse ends.
// The block handles one item at a time: in ready is low from acceptance
// until the last result is transferred. When the receiver stalls the
// current result holds on out_o and no new item is taken.
// Reset (rst_ni low) clears the frame and all pin state at once; the block
// is ready as soon as reset is released.
module bus_io_expander_pulse_timer #(
  parameter int PIN_COUNT   = 4,
  parameter int ANALOG_BITS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  bipt_in_if.sink    in_i,
  bipt_out_if.source out_o
);
  import bipt_pkg::*;

  cmd_t       cmd;
  stat_t      stat;
  res_t       res;
  logic [1:0] sel;

  bipt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_last_o  (out_o.last),
    .out_sel_o   (sel),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  bipt_dp #(.PIN_COUNT(PIN_COUNT), .ANALOG_BITS(ANALOG_BITS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .operation_i  (in_i.operation),
    .rx_byte_i    (in_i.rx_byte),
    .now_us_i     (in_i.now_us),
    .pin_levels_i (in_i.pin_levels),
    .analog_0_i   (in_i.analog_0),
    .analog_1_i   (in_i.analog_1),
    .analog_2_i   (in_i.analog_2),
    .analog_3_i   (in_i.analog_3),
    .sel_i        (sel),
    .res_o        (res)
  );

  // result fields
  assign out_o.result_kind  = res.kind;
  assign out_o.result_pin   = res.pin;
  assign out_o.result_value = res.value;
endmodule
